// ----- rtl/core/eas_pkg.sv -----
// eas_pkg: shared types and constants of the e-mail address syntax checker.
// Holds the character class codes, the token passed from front to back, and queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package eas_pkg;

    // Character bytes that the classifier looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Token queue between classifier and parser
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character classes
    typedef enum logic [2:0] {
        CLS_TERM,    // zero byte: end of string
        CLS_QUOTE,   // double quote
        CLS_AT,      // at sign
        CLS_DOT,     // period
        CLS_BSLASH,  // backslash
        CLS_PLAIN,   // printable, not special
        CLS_QPRINT,  // printable but special or space: legal only inside quotes
        CLS_CTRL     // control byte or 127 and above
    } t_cls;

    typedef struct packed {
        t_cls cls;
    } t_tok;

endpackage

// ----- rtl/core/email_address_syntax_checker_top.sv -----
// email_address_syntax_checker_top: streaming e-mail address / host name syntax checker.
// Instantiates eas_front, eas_queue and eas_back; depends on eas_pkg.
//
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------
// input     | in        | i_valid / o_ready  | i_char_byte[7:0]
// result    | out       | o_valid / i_ready  | o_address_ok
// config    | in        | i_cfg_wr_en        | i_cfg_wr_data (host mode)
//
// One byte request per cycle is sustained; the parse state machine in eas_back
// updates once per byte, and that single-cycle update sets the rate.
// A terminator's verdict reaches o_valid once its token is registered in the queue and,
// when nothing waits ahead of it, pops straight from there into the output register.
// Reset is synchronous, active low; it empties the queue and drops any pending verdict.
// A stalled result blocks only terminators; other bytes keep draining, and o_ready
// falls only once the two-entry token queue is full.
`timescale 1ns / 1ps

module email_address_syntax_checker_top
    import eas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_address_ok
);

    t_tok front_tok;
    t_tok q_tok;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic in_take;

    // Take a request whenever the queue has room
    assign o_ready = !q_full;
    assign in_take = i_valid && o_ready;

    // Classify the byte on the way in
    eas_front u_front (
        .i_char_byte (i_char_byte),
        .o_tok       (front_tok)
    );

    // Decouple classification from parsing
    eas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_take),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    // Advance the parse state and hold verdicts until taken
    eas_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tok_valid   (q_valid),
        .i_tok         (q_tok),
        .o_tok_pop     (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_address_ok  (o_address_ok)
    );

endmodule

// ----- rtl/core/eas_front.sv -----
// eas_front: classifies each incoming byte into a character class token.
// Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_front
    import eas_pkg::*;
(
    input  logic [7:0] i_char_byte,
    output t_tok       o_tok
);

    logic is_special;

    always_comb begin
        is_special = (i_char_byte == 8'h28) || (i_char_byte == 8'h29) ||
                     (i_char_byte == 8'h3C) || (i_char_byte == 8'h3E) ||
                     (i_char_byte == 8'h2C) || (i_char_byte == 8'h3B) ||
                     (i_char_byte == 8'h3A) || (i_char_byte == 8'h5B) ||
                     (i_char_byte == 8'h5D);
    end

    // Order decides: exact characters first, then ranges
    always_comb begin
        priority if (i_char_byte == CH_NUL) begin
            o_tok.cls = CLS_TERM;
        end else if (i_char_byte == CH_QUOTE) begin
            o_tok.cls = CLS_QUOTE;
        end else if (i_char_byte == CH_AT) begin
            o_tok.cls = CLS_AT;
        end else if (i_char_byte == CH_DOT) begin
            o_tok.cls = CLS_DOT;
        end else if (i_char_byte == CH_BSLASH) begin
            o_tok.cls = CLS_BSLASH;
        end else if (i_char_byte < CH_SPACE || i_char_byte >= CH_DEL) begin
            o_tok.cls = CLS_CTRL;
        end else if (i_char_byte == CH_SPACE || is_special) begin
            o_tok.cls = CLS_QPRINT;
        end else begin
            o_tok.cls = CLS_PLAIN;
        end
    end

endmodule

// ----- rtl/core/eas_queue.sv -----
// eas_queue: short token FIFO between classifier and parser.
// Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_queue
    import eas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_tok o_tok
);

    t_tok              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

// ----- rtl/core/eas_back.sv -----
// eas_back: parse state machine over class tokens, with the verdict output register.
// Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_back
    import eas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    input  logic i_tok_valid,
    input  t_tok i_tok,
    output logic o_tok_pop,
    output logic o_valid,
    input  logic i_ready,
    output logic o_address_ok
);

    typedef enum logic [2:0] {
        PH_NAME,
        PH_QUOTED,
        PH_ESCAPE,
        PH_AFTER_QUOTE,
        PH_DOMAIN,
        PH_FAILED
    } t_phase;

    t_phase r_phase, n_phase;
    logic   r_fresh, n_fresh;
    logic   r_last_dot, n_last_dot;
    logic   r_dom_dot, n_dom_dot;
    logic   r_host;
    logic   r_out_valid, n_out_valid;
    logic   r_out_ok, n_out_ok;

    t_phase cur_phase;
    logic   is_term;
    logic   out_free;

    assign is_term   = (i_tok.cls == CLS_TERM);
    assign out_free  = !r_out_valid || i_ready;
    assign o_tok_pop = i_tok_valid && (!is_term || out_free);
    assign cur_phase = r_fresh ? (r_host ? PH_DOMAIN : PH_NAME) : r_phase;

    assign o_valid      = r_out_valid;
    assign o_address_ok = r_out_ok;

    always_comb begin
        n_phase     = r_phase;
        n_fresh     = r_fresh;
        n_last_dot  = r_last_dot;
        n_dom_dot   = r_dom_dot;
        n_out_valid = r_out_valid && !i_ready;
        n_out_ok    = r_out_ok;

        if (o_tok_pop) begin
            if (is_term) begin
                // Give the verdict and start a new string
                n_out_valid = 1'b1;
                n_out_ok    = r_fresh || (r_phase == PH_DOMAIN && r_dom_dot);
                n_phase     = PH_NAME;
                n_fresh     = 1'b1;
                n_last_dot  = 1'b0;
                n_dom_dot   = 1'b0;
            end else begin
                n_fresh = 1'b0;
                n_phase = cur_phase;
                unique case (cur_phase)
                    PH_NAME: begin
                        unique case (i_tok.cls)
                            CLS_QUOTE: begin
                                n_phase = (r_fresh || r_last_dot) ? PH_QUOTED : PH_FAILED;
                            end
                            CLS_AT: begin
                                if (r_fresh || r_last_dot) begin
                                    n_phase = PH_FAILED;
                                end else begin
                                    n_phase    = PH_DOMAIN;
                                    n_last_dot = 1'b1;
                                    n_dom_dot  = 1'b0;
                                end
                            end
                            CLS_DOT:   n_last_dot = 1'b1;
                            CLS_PLAIN: n_last_dot = 1'b0;
                            default:   n_phase = PH_FAILED;
                        endcase
                    end
                    PH_QUOTED: begin
                        unique case (i_tok.cls)
                            CLS_QUOTE:  n_phase = PH_AFTER_QUOTE;
                            CLS_BSLASH: n_phase = PH_ESCAPE;
                            CLS_CTRL:   n_phase = PH_FAILED;
                            default:    n_phase = PH_QUOTED;
                        endcase
                    end
                    PH_ESCAPE: begin
                        n_phase = (i_tok.cls == CLS_CTRL) ? PH_FAILED : PH_QUOTED;
                    end
                    PH_AFTER_QUOTE: begin
                        unique case (i_tok.cls)
                            CLS_DOT: begin
                                n_phase    = PH_NAME;
                                n_last_dot = 1'b1;
                            end
                            CLS_AT: begin
                                n_phase    = PH_DOMAIN;
                                n_last_dot = 1'b1;
                                n_dom_dot  = 1'b0;
                            end
                            default: n_phase = PH_FAILED;
                        endcase
                    end
                    PH_DOMAIN: begin
                        unique case (i_tok.cls)
                            CLS_DOT: begin
                                if (r_fresh || r_last_dot) begin
                                    n_phase = PH_FAILED;
                                end else begin
                                    n_dom_dot  = 1'b1;
                                    n_last_dot = 1'b1;
                                end
                            end
                            CLS_PLAIN: n_last_dot = 1'b0;
                            default:   n_phase = PH_FAILED;
                        endcase
                    end
                    default: n_phase = PH_FAILED;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NAME;
            r_fresh     <= 1'b1;
            r_last_dot  <= 1'b0;
            r_dom_dot   <= 1'b0;
            r_host      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_ok    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_fresh     <= n_fresh;
            r_last_dot  <= n_last_dot;
            r_dom_dot   <= n_dom_dot;
            r_out_valid <= n_out_valid;
            r_out_ok    <= n_out_ok;
            if (i_cfg_wr_en) begin
                r_host <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ----- rtl/core/eas_checker.sv -----
// eas_checker: port-level assertions for the syntax checker, bound to the top level.
// Depends on email_address_syntax_checker_top.
`timescale 1ns / 1ps

module eas_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_address_ok
);

    // A stalled verdict holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_address_ok))
        else $error("verdict dropped or changed while stalled");

    // Queue starts empty after reset
    a_ready_after_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_ready)
        else $error("input not ready right after reset");

    // Queue fills only by taking requests
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid && o_ready))
        else $error("ready dropped with no request taken");

    // A verdict can only appear from a taken request
    a_verdict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_rst_n) && !($past(o_ready) && $past(o_ready, 2)
            && !$past(i_valid) && !$past(i_valid, 2)))
        else $error("verdict appeared without a preceding request");

endmodule

bind email_address_syntax_checker_top eas_checker u_eas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_address_ok (o_address_ok)
);

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for email_address_syntax_checker_top.
// Streams string bytes into the checker, predicts each verdict, and compares it with the output.
// Depends on eas_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb_top;
    import eas_pkg::*;

    localparam int LONG_STALL    = 300;  // cycles the result side holds off once
    localparam int SETTLE_CYCLES = 16;   // pause after the last verdict before a write

    typedef enum logic [2:0] {
        ST_NAME,
        ST_QUOTED,
        ST_ESCAPE,
        ST_AFTER_QUOTE,
        ST_DOMAIN,
        ST_FAILED
    } t_parse_st;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_char_byte   = 8'h00;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_address_ok;

    email_address_syntax_checker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_byte   (i_char_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_address_ok  (o_address_ok)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Byte stream waiting to be offered, and verdicts owed by the checker
    logic [7:0] pending_bytes[$];
    bit         due_verdicts[$];
    logic [7:0] word[$];           // string under construction

    int  mismatches    = 0;
    int  queued_bytes  = 0;
    int  src_idle_pct  = 0;
    int  snk_idle_pct  = 0;
    int  src_gap       = 0;
    int  snk_gap       = 0;
    int  stall_left    = 0;
    bit  quiet_tail    = 1'b0;
    bit  stall_request = 1'b0;
    bit  stall_served  = 1'b0;
    bit  gen_host      = 1'b0;
    bit  req_fire      = 1'b0;     // byte request taken at the last rising edge

    // Mirror of the parser state
    t_parse_st st_m;
    bit        host_mode_m;
    bit        fresh_m;
    bit        prev_dot_m;
    bit        dom_dot_m;

    function automatic bit is_special(input logic [7:0] b);
        return b == "(" || b == ")" || b == "<" || b == ">" || b == CH_AT ||
               b == "," || b == ";" || b == ":" || b == CH_BSLASH || b == CH_QUOTE ||
               b == "[" || b == "]";
    endfunction

    function automatic bit is_bad_plain(input logic [7:0] b);
        return b <= CH_SPACE || b >= CH_DEL || is_special(b);
    endfunction

    function automatic void restart_string();
        st_m       = host_mode_m ? ST_DOMAIN : ST_NAME;
        fresh_m    = 1'b1;
        prev_dot_m = 1'b0;
        dom_dot_m  = 1'b0;
    endfunction

    // Advance the parser mirror by one byte; return 1 when a verdict is owed.
    function automatic bit take_byte(input logic [7:0] b, output bit ok);
        bit first;
        ok = 1'b0;
        if (b == CH_NUL) begin
            if (fresh_m)
                ok = 1'b1;
            else if (st_m == ST_DOMAIN)
                ok = dom_dot_m;
            restart_string();
            return 1'b1;
        end
        if (fresh_m)
            st_m = host_mode_m ? ST_DOMAIN : ST_NAME;
        first   = fresh_m;
        fresh_m = 1'b0;
        case (st_m)
            ST_NAME: begin
                if (b == CH_QUOTE) begin
                    st_m = (first || prev_dot_m) ? ST_QUOTED : ST_FAILED;
                end else if (b == CH_AT) begin
                    if (first || prev_dot_m) begin
                        st_m = ST_FAILED;
                    end else begin
                        // entering the domain counts as a dot, so a leading dot fails
                        st_m       = ST_DOMAIN;
                        prev_dot_m = 1'b1;
                        dom_dot_m  = 1'b0;
                    end
                end else if (is_bad_plain(b)) begin
                    st_m = ST_FAILED;
                end else begin
                    prev_dot_m = (b == CH_DOT);
                end
            end
            ST_QUOTED: begin
                if (b == CH_QUOTE)
                    st_m = ST_AFTER_QUOTE;
                else if (b == CH_BSLASH)
                    st_m = ST_ESCAPE;
                else if (b < CH_SPACE || b >= CH_DEL)
                    st_m = ST_FAILED;
            end
            ST_ESCAPE: begin
                st_m = (b < CH_SPACE || b >= CH_DEL) ? ST_FAILED : ST_QUOTED;
            end
            ST_AFTER_QUOTE: begin
                if (b == CH_DOT) begin
                    st_m       = ST_NAME;
                    prev_dot_m = 1'b1;
                end else if (b == CH_AT) begin
                    st_m       = ST_DOMAIN;
                    prev_dot_m = 1'b1;
                    dom_dot_m  = 1'b0;
                end else begin
                    st_m = ST_FAILED;
                end
            end
            ST_DOMAIN: begin
                if (b == CH_DOT) begin
                    if (first || prev_dot_m) begin
                        st_m = ST_FAILED;
                    end else begin
                        dom_dot_m  = 1'b1;
                        prev_dot_m = 1'b1;
                    end
                end else if (is_bad_plain(b)) begin
                    st_m = ST_FAILED;
                end else begin
                    prev_dot_m = 1'b0;
                end
            end
            default: st_m = ST_FAILED;
        endcase
        return 1'b0;
    endfunction

    // Sample at the rising edge: predict on taken requests, check delivered verdicts.
    always @(posedge i_clk) begin : watch
        bit verdict;
        bit owed;
        if (!i_rst_n) begin
            req_fire    <= 1'b0;
            host_mode_m = 1'b0;
            restart_string();
        end else begin
            req_fire <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (due_verdicts.size() == 0) begin
                    mismatches++;
                    $display("%0t: verdict with none expected, actual %0b",
                             $realtime, o_address_ok);
                end else begin
                    verdict = due_verdicts.pop_front();
                    if (o_address_ok !== verdict) begin
                        mismatches++;
                        $display("%0t: address_ok mismatch, expected %0b actual %0b",
                                 $realtime, verdict, o_address_ok);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                host_mode_m = i_cfg_wr_data;
                if (fresh_m)
                    restart_string();
            end
            if (i_valid && o_ready) begin
                owed = take_byte(i_char_byte, verdict);
                if (owed)
                    due_verdicts.push_back(verdict);
            end
        end
    end

    // Byte driver: hold the request until taken, then advance or idle in bursts.
    always @(negedge i_clk) begin : byte_source
        if (!i_valid || req_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
                i_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(99) < src_idle_pct) begin
                src_gap = $urandom_range(14);
                i_valid <= 1'b0;
            end else begin
                i_valid     <= 1'b1;
                i_char_byte <= pending_bytes.pop_front();
            end
        end
    end

    // Verdict side: random stall bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin : verdict_sink
        if (stall_request && !stall_served) begin
            stall_left   = LONG_STALL;
            stall_served = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            i_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(99) < snk_idle_pct) begin
            snk_gap = $urandom_range(14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
        pending_bytes.push_back(CH_NUL);
        queued_bytes += s.len() + 1;
    endtask

    task automatic emit_word();
        foreach (word[i])
            pending_bytes.push_back(word[i]);
        pending_bytes.push_back(CH_NUL);
        queued_bytes += word.size() + 1;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(126, 33));
        while (is_special(c) || c == CH_DOT);
        return c;
    endfunction

    task automatic add_quoted();
        int n;
        logic [7:0] c;
        n = $urandom_range(4);
        word.push_back(CH_QUOTE);
        repeat (n) begin
            c = 8'($urandom_range(126, 32));
            if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(7) == 0)
                word.push_back(CH_BSLASH);
            word.push_back(c);
        end
        word.push_back(CH_QUOTE);
    endtask

    task automatic add_name();
        int parts;
        parts = $urandom_range(3, 1);
        for (int i = 0; i < parts; i++) begin
            if (i > 0)
                word.push_back(CH_DOT);
            if ($urandom_range(3) == 0)
                add_quoted();
            else
                repeat ($urandom_range(4, 1)) word.push_back(plain_char());
        end
    endtask

    task automatic add_domain();
        int labels;
        labels = $urandom_range(3, 1);
        for (int i = 0; i < labels; i++) begin
            if (i > 0)
                word.push_back(CH_DOT);
            repeat ($urandom_range(4, 1)) word.push_back(plain_char());
        end
        if ($urandom_range(5) == 0)
            word.push_back(CH_DOT);
    endtask

    // Alter a well-formed string in at most one place, which may break it.
    task automatic mangle();
        int pos;
        pos = $urandom_range(word.size());
        case ($urandom_range(3))
            0: word.insert(pos, 8'($urandom_range(255, 1)));
            1: if (pos < word.size()) word[pos] = 8'($urandom_range(255, 1));
            2: if (pos < word.size()) word.delete(pos);
            default: word.insert(pos, $urandom_range(1) ? CH_DOT : CH_AT);
        endcase
    endtask

    task automatic random_phase(input int budget);
        int target;
        target = queued_bytes + budget;
        while (queued_bytes < target) begin
            word.delete();
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(6)) word.push_back(8'($urandom_range(255, 1)));
            end else begin
                if (!gen_host) begin
                    add_name();
                    word.push_back(CH_AT);
                end
                add_domain();
                if ($urandom_range(99) < 30)
                    mangle();
            end
            emit_word();
        end
    endtask

    // Wait until every byte is taken and every verdict delivered, then settle.
    task automatic drain();
        while (pending_bytes.size() != 0 || i_valid || due_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_host_mode(input bit host);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= host;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        gen_host = host;
    endtask

    initial begin : stimulus
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Address mode straight out of reset: empty, good, quoted with escape,
        // '@' after a dot, missing '@', control in quotes, DEL and 0xFF bytes,
        // junk after a closing quote.
        src_idle_pct = 20;
        snk_idle_pct = 20;
        push_text("");
        push_text("a@b.c");
        push_text("\"\\\"~\"@x.");
        push_text("a.@b");
        push_text("a");
        push_text("\"\001\"");
        push_text("b\177\377");
        push_text("\"\"x@b.c");
        drain();

        // Host mode: leading dot, empty label, trailing dot, space, high byte
        set_host_mode(1'b1);
        push_text(".a");
        push_text("a..b");
        push_text("x.y.");
        push_text(" ");
        push_text("\200");
        drain();

        set_host_mode(1'b0);
        src_idle_pct = 10;
        snk_idle_pct = 25;
        random_phase(480);
        drain();

        set_host_mode(1'b1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(250);
        drain();

        // Hold the verdict side off while short strings keep coming, so the
        // token queue fills and the byte request side stalls.
        set_host_mode(1'b0);
        stall_request = 1'b1;
        repeat (12) begin
            push_text("");
            push_text("a@b.c");
        end
        drain();

        set_host_mode(1'b0);
        src_idle_pct = 30;
        snk_idle_pct = 40;
        random_phase(350);
        drain();

        set_host_mode(1'b1);
        src_idle_pct = 25;
        snk_idle_pct = 5;
        random_phase(130);
        drain();

        // Closing stretch at full rate
        set_host_mode(1'b0);
        quiet_tail = 1'b1;
        random_phase(200);
        drain();

        if (mismatches == 0 && due_verdicts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/eas_pkg.sv
rtl/core/eas_front.sv
rtl/core/eas_queue.sv
rtl/core/eas_back.sv
rtl/core/email_address_syntax_checker_top.sv
rtl/core/eas_checker.sv
tb/tb_top.sv
